>>> rtl/gisc_pkg.sv
// ----------------------------------------------------------------------------
// gisc_pkg
// Shared types, constants and modular add for the grid independent set
// counter.
// ----------------------------------------------------------------------------
package gisc_pkg;

    localparam int COUNT_W   = 27;
    localparam int BLOCKED_W = 12;
    localparam int CFG_W     = 4;

    localparam logic [COUNT_W:0] COUNT_MODULUS = 28'd100000000;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_XFORM  = 6'b000010,
        ST_XDRAIN = 6'b000100,
        ST_WRITE  = 6'b001000,
        ST_WDRAIN = 6'b010000,
        ST_DONE   = 6'b100000
    } gisc_state_t;

    typedef struct packed {
        logic [BLOCKED_W-1:0] blocked_mask;
        logic                 last_row;
    } gisc_item_t;

    function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= COUNT_MODULUS) begin
            s = s - COUNT_MODULUS;
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

>>> rtl/grid_independent_set_counter_top.sv
// ----------------------------------------------------------------------------
// grid_independent_set_counter_top
// Counts independent markings of a grid with blocked cells, one row per item,
// modulo 100000000; the count comes out on the last row.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake          Payload
//  s_        in    tvalid / tready    tdata[11:0] blocked_mask, tlast last_row
//  m_        out   tvalid / tready    tdata[26:0] placement_count
//  cfg_      in    cfg_we             cfg_wdata[3:0] column_count
//
//  The subset-sum pass does one read-modify-write on the count table a cycle, pausing in a drain state after each bit.
//  Reset clears control only; the tables are never read before written.
//  A result waits in the output register while the next row is worked on.
//  A last row holds in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module grid_independent_set_counter_top
    import gisc_pkg::*;
#(
    parameter int MAX_COLUMNS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // column_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [11:0] blocked_mask
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata         // [26:0] placement_count
);

    logic [CFG_W-1:0]   column_count_reg;
    logic               m_tvalid_reg;
    logic [COUNT_W-1:0] m_count_reg;

    gisc_item_t                item;
    logic                      res_ready;
    logic                      res_valid;
    logic [COUNT_W-1:0]        res_count;
    logic                      we0, we1;
    logic [MAX_COLUMNS-1:0]    waddr, raddr_a, raddr_b;
    logic [COUNT_W-1:0]        wdata;
    logic [COUNT_W-1:0]        rd0_a, rd0_b, rd1_a, rd1_b;

    assign item.blocked_mask = s_tdata[BLOCKED_W-1:0];
    assign item.last_row     = s_tlast;
    assign res_ready         = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= 4'd12;
        end else if (cfg_we) begin
            column_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_count_reg <= res_count;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(32-COUNT_W){1'b0}}, m_count_reg};

    gisc_engine #(
        .W (MAX_COLUMNS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .column_count (column_count_reg),
        .item_valid   (s_tvalid),
        .item         (item),
        .item_ready   (s_tready),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res_count    (res_count),
        .we0          (we0),
        .we1          (we1),
        .waddr        (waddr),
        .wdata        (wdata),
        .raddr_a      (raddr_a),
        .raddr_b      (raddr_b),
        .rd0_a        (rd0_a),
        .rd0_b        (rd0_b),
        .rd1_a        (rd1_a),
        .rd1_b        (rd1_b)
    );

    gisc_ram #(
        .AW (MAX_COLUMNS),
        .DW (COUNT_W)
    ) u_ram0 (
        .aclk    (aclk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    gisc_ram #(
        .AW (MAX_COLUMNS),
        .DW (COUNT_W)
    ) u_ram1 (
        .aclk    (aclk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

endmodule

>>> rtl/gisc_ram.sv
// ----------------------------------------------------------------------------
// gisc_ram
// Count table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gisc_ram #(
    parameter int AW = 12,
    parameter int DW = 27
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rdata_a_reg;
    logic [DW-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/gisc_engine.sv
// ----------------------------------------------------------------------------
// gisc_engine
// Row sequencer: in-place subset-sum pass over the previous-row table, then
// a sweep that writes the new row into the other table and sums it; the pass is skipped on a grid's first row.
// ----------------------------------------------------------------------------
module gisc_engine
    import gisc_pkg::*;
#(
    parameter int W = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CFG_W-1:0]   column_count,
    input  logic               item_valid,
    input  gisc_item_t         item,
    output logic               item_ready,
    input  logic               res_ready,
    output logic               res_valid,
    output logic [COUNT_W-1:0] res_count,
    output logic               we0,
    output logic               we1,
    output logic [W-1:0]       waddr,
    output logic [COUNT_W-1:0] wdata,
    output logic [W-1:0]       raddr_a,
    output logic [W-1:0]       raddr_b,
    input  logic [COUNT_W-1:0] rd0_a,
    input  logic [COUNT_W-1:0] rd0_b,
    input  logic [COUNT_W-1:0] rd1_a,
    input  logic [COUNT_W-1:0] rd1_b
);

    localparam int          WIDTH_W  = $clog2(W + 1);
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam logic [4:0]  MAX_COLS = 5'(W);

    gisc_state_t          state_reg, state_next;
    logic                 first_reg, first_next;
    logic                 bank_reg, bank_next;
    logic                 last_reg, last_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [WIDTH_W-1:0]   bit_reg, bit_next;
    logic [W-1:0]         blocked_reg, blocked_next;
    logic [W-1:0]         idx_reg, idx_next;
    logic                 pend_x_reg, pend_x_next;
    logic                 pend_w_reg, pend_w_next;
    logic                 pend_set_reg, pend_set_next;
    logic [W-1:0]         pend_addr_reg, pend_addr_next;
    logic [COUNT_W-1:0]   total_reg, total_next;

    logic [4:0]           col_ext;
    logic [WIDTH_W-1:0]   width_in;
    logic [W-1:0]         full;
    logic [W-1:0]         bit_mask;
    logic [COUNT_W-1:0]   prev_a, prev_b;
    logic [COUNT_W-1:0]   xsum;
    logic                 allowed;
    logic [COUNT_W-1:0]   new_val;
    logic                 xwrite;

    assign col_ext  = {1'b0, column_count};
    assign width_in = WIDTH_W'((col_ext > MAX_COLS) ? MAX_COLS : col_ext);
    assign full     = ~(ALL_ONES << width_reg);
    assign bit_mask = W'(1) << bit_reg;

    assign prev_a = bank_reg ? rd1_a : rd0_a;
    assign prev_b = bank_reg ? rd1_b : rd0_b;
    assign xsum   = add_mod(prev_a, prev_b);

    assign allowed = ((pend_addr_reg & ~full) == '0)
                  && ((pend_addr_reg & (pend_addr_reg << 1)) == '0)
                  && ((pend_addr_reg & blocked_reg) == '0);
    assign new_val = allowed ? (first_reg ? COUNT_W'(1) : prev_a) : '0;

    assign xwrite  = pend_x_reg & pend_set_reg;
    assign we0     = (xwrite & ~bank_reg) | (pend_w_reg & bank_reg);
    assign we1     = (xwrite & bank_reg) | (pend_w_reg & ~bank_reg);
    assign waddr   = pend_addr_reg;
    assign wdata   = pend_w_reg ? new_val : xsum;
    assign raddr_a = (state_reg == ST_WRITE) ? (full & ~idx_reg) : idx_reg;
    assign raddr_b = idx_reg ^ bit_mask;

    assign item_ready = (state_reg == ST_IDLE);
    assign res_count  = total_reg;

    always_comb begin
        state_next     = state_reg;
        first_next     = first_reg;
        bank_next      = bank_reg;
        last_next      = last_reg;
        width_next     = width_reg;
        bit_next       = bit_reg;
        blocked_next   = blocked_reg;
        idx_next       = idx_reg;
        pend_x_next    = 1'b0;
        pend_w_next    = 1'b0;
        pend_set_next  = 1'b0;
        pend_addr_next = idx_reg;
        total_next     = total_reg;
        res_valid      = 1'b0;

        if (pend_w_reg) begin
            total_next = add_mod(total_reg, new_val);
        end

        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    width_next   = width_in;
                    blocked_next = W'(item.blocked_mask);
                    last_next    = item.last_row;
                    bit_next     = '0;
                    idx_next     = '0;
                    total_next   = '0;
                    if (first_reg || width_in == '0) begin
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_XFORM;
                    end
                end
            end
            ST_XFORM: begin
                pend_x_next   = 1'b1;
                pend_set_next = |(idx_reg & bit_mask);
                if (idx_reg == full) begin
                    idx_next   = '0;
                    state_next = ST_XDRAIN;
                end else begin
                    idx_next = idx_reg + W'(1);
                end
            end
            ST_XDRAIN: begin
                if (bit_reg == width_reg - WIDTH_W'(1)) begin
                    bit_next   = '0;
                    state_next = ST_WRITE;
                end else begin
                    bit_next   = bit_reg + WIDTH_W'(1);
                    state_next = ST_XFORM;
                end
            end
            ST_WRITE: begin
                pend_w_next = 1'b1;
                if (idx_reg == ALL_ONES) begin
                    idx_next   = '0;
                    state_next = ST_WDRAIN;
                end else begin
                    idx_next = idx_reg + W'(1);
                end
            end
            ST_WDRAIN: begin
                bank_next  = ~bank_reg;
                first_next = last_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            first_reg  <= 1'b1;
            bank_reg   <= 1'b0;
            pend_x_reg <= 1'b0;
            pend_w_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            bank_reg   <= bank_next;
            pend_x_reg <= pend_x_next;
            pend_w_reg <= pend_w_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg      <= last_next;
        width_reg     <= width_next;
        bit_reg       <= bit_next;
        blocked_reg   <= blocked_next;
        idx_reg       <= idx_next;
        pend_set_reg  <= pend_set_next;
        pend_addr_reg <= pend_addr_next;
        total_reg     <= total_next;
    end

endmodule
